FILE: hdl/mlc_pkg.sv
// ----------------------------------------------------------------------------
// mlc_pkg
// Shared types and constants of the continuous mu-law / A-law compressor.
// ----------------------------------------------------------------------------
package mlc_pkg;

  localparam int SAMPLE_BITS_DEF = 16;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int MAG_W     = 15;
  localparam int K_W       = 16;

  localparam int FRAC_U = 20;
  localparam int FRAC_P = 28;

  localparam int N1_W   = MAG_W + FRAC_U + 1;
  localparam int U_W    = FRAC_U + 1;
  localparam int KU_W   = K_W + U_W;
  localparam int LN_W   = 23;
  localparam int LN_ITER = FRAC_U;
  localparam int LN_LAT = LN_ITER + 3;

  localparam int NUM_W  = FRAC_P;
  localparam int DEN_W  = 32;
  localparam int PROD_W = MAG_W + NUM_W;
  localparam int N2_W   = PROD_W + 1;
  localparam int Q_W    = 16;

  localparam logic [31:0]    LN2_Q32 = 32'd2977044472;
  localparam logic [K_W-1:0] K_ONE   = 16'h0100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LAW = 2'd0,
    REG_K   = 2'd1,
    REG_MAX = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    LAW_MU = 1'b0,
    LAW_A  = 1'b1
  } law_e;

  typedef struct packed {
    logic neg;
    logic zero;
    logic over;
  } flag_t;

  typedef struct packed {
    logic              below_one;
    logic [NUM_W-1:0]  ku_lo;
  } lnside_t;

endpackage

FILE: hdl/mlc_div.sv
// ----------------------------------------------------------------------------
// mlc_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module mlc_div #(
  parameter int NW = 36,
  parameter int DW = 15,
  parameter int QW = 21
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  logic [DW-1:0] rem_q [0:QW-1];
  logic [QW-1:0] low_q [0:QW-1];
  logic [DW-1:0] den_q [0:QW-1];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [QW-1:0] low_in;
    logic [DW-1:0] den_in;
    logic [DW:0]   trial;
    logic          ge;

    if (s == 0) begin : g_first
      assign rem_in = DW'(num_i[NW-1:QW]);
      assign low_in = num_i[QW-1:0];
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign low_in = low_q[s-1];
      assign den_in = den_q[s-1];
    end

    assign trial = {rem_in, low_in[QW-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= ge ? DW'(trial - {1'b0, den_in}) : DW'(trial);
        low_q[s] <= {low_in[QW-2:0], ge};
        den_q[s] <= den_in;
      end
    end
  end

  assign quo_o = low_q[QW-1];

endmodule

FILE: hdl/mlc_ln.sv
// ----------------------------------------------------------------------------
// mlc_ln
// Pipelined natural logarithm: normalise, one squaring step per stage,
// scale by ln 2 and round.
// ----------------------------------------------------------------------------
module mlc_ln (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [mlc_pkg::KU_W-1:0]      v_i,
  output logic [mlc_pkg::LN_W-1:0]      ln_o
);

  localparam int VW   = mlc_pkg::KU_W;
  localparam int FP   = mlc_pkg::FRAC_P;
  localparam int IT   = mlc_pkg::LN_ITER;
  localparam int EMAX = VW - 1 - FP;
  localparam int EW   = $clog2(EMAX + 1);
  localparam int MWL  = 31;
  localparam int PW   = EW + IT + 32;

  logic [MWL-1:0] m_q  [0:IT];
  logic [EW-1:0]  e_q  [0:IT];
  logic           z_q  [0:IT];
  logic [IT-1:0]  fr_q [0:IT];

  logic [EW-1:0]  e_n;
  logic [VW-1:0]  sh_n;
  logic           z_n;

  always_comb begin
    e_n = '0;
    for (int i = 0; i <= EMAX; i++) begin
      if (v_i[FP+i]) begin
        e_n = EW'(i);
      end
    end
    sh_n = v_i << (EW'(EMAX) - e_n);
    z_n  = ~|v_i[VW-1:FP];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0]  <= sh_n[VW-1 -: MWL];
      e_q[0]  <= e_n;
      z_q[0]  <= z_n;
      fr_q[0] <= '0;
    end
  end

  for (genvar i = 0; i < IT; i++) begin : g_sq
    logic [2*MWL-1:0] sq;
    logic [MWL:0]     s;

    assign sq = m_q[i] * m_q[i];
    assign s  = sq[2*MWL-1:MWL-1];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[i+1]  <= s[MWL] ? s[MWL:1] : s[MWL-1:0];
        e_q[i+1]  <= e_q[i];
        z_q[i+1]  <= z_q[i];
        fr_q[i+1] <= fr_q[i] | (IT'(s[MWL]) << (IT-1-i));
      end
    end
  end

  logic [PW-1:0]   p_q;
  logic            zp_q;
  logic [PW:0]     r;
  logic [mlc_pkg::LN_W-1:0] ln_q;

  assign r = {1'b0, p_q} + (PW+1)'(64'h8000_0000);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q  <= PW'({e_q[IT], fr_q[IT]}) * PW'(mlc_pkg::LN2_Q32);
      zp_q <= z_q[IT];
      ln_q <= zp_q ? '0 : r[32 +: mlc_pkg::LN_W];
    end
  end

  assign ln_o = ln_q;

endmodule

FILE: hdl/mu_a_law_compressor_core.sv
// ----------------------------------------------------------------------------
// mu_a_law_compressor_core
// Continuous mu-law / A-law compressor, one sample in, one sample out.
//
//   channel   signals                          direction  width
//   input     in_valid_i in_stall_o sample_in_i  in        SAMPLE_BITS
//   output    out_valid_o out_stall_i sample_out_o out     SAMPLE_BITS
//   config    cfg_we_i cfg_idx_i cfg_data_i      in        2 / 16
//
// Samples enter one per cycle while in_stall_o is low; 66 register stages:
// the 21- and 16-stage dividers, the 23-stage logarithm pipelines and six
// single stages.
// Reset clears all valid bits and loads the register defaults.
// A stalled result freezes the whole pipeline; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module mu_a_law_compressor_core #(
  parameter int SAMPLE_BITS = mlc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]       sample_in_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]       sample_out_o,
  input  logic                                cfg_we_i,
  input  logic [mlc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [mlc_pkg::CFG_W-1:0]           cfg_data_i
);

  localparam int SB    = SAMPLE_BITS;
  localparam int MW    = mlc_pkg::MAG_W;
  localparam int FU    = mlc_pkg::FRAC_U;
  localparam int FP    = mlc_pkg::FRAC_P;
  localparam int UW    = mlc_pkg::U_W;
  localparam int KUW   = mlc_pkg::KU_W;
  localparam int LNW   = mlc_pkg::LN_W;
  localparam int LAT   = mlc_pkg::LN_LAT;
  localparam int NUMW  = mlc_pkg::NUM_W;
  localparam int DENW  = mlc_pkg::DEN_W;
  localparam int QW    = mlc_pkg::Q_W;
  localparam int CW    = (SB > MW) ? SB : MW;
  localparam int CW2   = (SB > QW) ? SB : QW;

  localparam int I_B   = UW + 1;
  localparam int I_L   = I_B + LAT;
  localparam int I_C   = I_L + 1;
  localparam int I_D   = I_C + 1;
  localparam int I_E   = I_D + 1;
  localparam int TOT   = I_E + QW + 1;

  localparam logic [SB-2:0]   FULL  = '1;
  localparam logic [KUW-1:0]  ONE_P = KUW'(64'd1 << FP);
  localparam logic [DENW-1:0] ONE_L = DENW'(64'd1 << FU);

  // configuration registers
  mlc_pkg::law_e   law_q;
  logic [mlc_pkg::K_W-1:0] k_q;
  logic [MW-1:0]   max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      law_q <= mlc_pkg::LAW_MU;
      k_q   <= mlc_pkg::K_ONE;
      max_q <= '1;
    end else if (cfg_we_i) begin
      case (mlc_pkg::cfg_idx_e'(cfg_idx_i))
        mlc_pkg::REG_LAW: law_q <= mlc_pkg::law_e'(cfg_data_i[0]);
        mlc_pkg::REG_K:   k_q   <= cfg_data_i;
        mlc_pkg::REG_MAX: max_q <= cfg_data_i[MW-1:0];
        default: ;
      endcase
    end
  end

  logic [mlc_pkg::K_W-1:0] k_eff;
  logic [MW-1:0]           m_eff;

  assign k_eff = (k_q < mlc_pkg::K_ONE) ? mlc_pkg::K_ONE : k_q;
  assign m_eff = (max_q == '0) ? MW'(1) : max_q;

  // pipeline advance
  logic en;
  logic out_valid_q;
  logic [SB-1:0] sample_out_q;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  logic [TOT-1:0]        vld_q;
  mlc_pkg::flag_t        fl_q [0:TOT-1];
  mlc_pkg::lnside_t      ls_q [0:LAT-1];

  // stage A: sign, magnitude, range checks, normalising dividend
  logic [SB-1:0]  x_u;
  logic [SB-1:0]  a_abs;
  logic [CW-1:0]  a_ext;
  mlc_pkg::flag_t fl_a;
  logic [mlc_pkg::N1_W-1:0] n1_q;

  assign x_u      = sample_in_i;
  assign fl_a.neg = x_u[SB-1];
  assign a_abs    = fl_a.neg ? (~x_u + SB'(1)) : x_u;
  assign a_ext    = CW'(a_abs);
  assign fl_a.zero = (a_abs == '0);
  assign fl_a.over = a_ext > CW'(m_eff);

  always_ff @(posedge clk_i) begin
    if (en) begin
      n1_q <= mlc_pkg::N1_W'({a_ext[MW-1:0], FU'(0)}) + mlc_pkg::N1_W'(m_eff >> 1);
    end
  end

  logic [UW-1:0] u;

  mlc_div #(
    .NW(mlc_pkg::N1_W),
    .DW(MW),
    .QW(UW)
  ) u_div_norm (
    .clk_i(clk_i),
    .en_i (en),
    .num_i(n1_q),
    .den_i(m_eff),
    .quo_o(u)
  );

  // stage B: K * u
  logic [KUW-1:0] ku_q;
  logic [KUW-1:0] k_sh;
  logic [KUW-1:0] v_num;
  logic [KUW-1:0] v_den;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ku_q <= KUW'(k_eff) * KUW'(u);
    end
  end

  assign k_sh  = KUW'({k_eff, FU'(0)});
  assign v_num = (law_q == mlc_pkg::LAW_A) ? ku_q : ku_q + ONE_P;
  assign v_den = (law_q == mlc_pkg::LAW_A) ? k_sh : k_sh + ONE_P;

  logic [LNW-1:0] ln_num;
  logic [LNW-1:0] ln_den;

  mlc_ln u_ln_num (
    .clk_i(clk_i),
    .en_i (en),
    .v_i  (v_num),
    .ln_o (ln_num)
  );

  mlc_ln u_ln_den (
    .clk_i(clk_i),
    .en_i (en),
    .v_i  (v_den),
    .ln_o (ln_den)
  );

  // stage C: select numerator and denominator of the final quotient
  mlc_pkg::lnside_t ls_l;
  logic [DENW-1:0]  den1;
  logic [NUMW-1:0]  num_c_q;
  logic [DENW-1:0]  den_c_q;

  assign ls_l = ls_q[LAT-1];
  assign den1 = ONE_L + DENW'(ln_den);

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (law_q == mlc_pkg::LAW_MU) begin
        num_c_q <= NUMW'(ln_num);
        den_c_q <= DENW'(ln_den);
      end else if (ls_l.below_one) begin
        num_c_q <= ls_l.ku_lo;
        den_c_q <= den1 << (FP - FU);
      end else begin
        num_c_q <= NUMW'(ONE_L + DENW'(ln_num));
        den_c_q <= den1;
      end
    end
  end

  // stage D: M * numerator; stage E: add half the divisor
  logic [mlc_pkg::PROD_W-1:0] prod_q;
  logic [DENW-1:0]            den_d_q;
  logic [mlc_pkg::N2_W-1:0]   n2_q;
  logic [DENW-1:0]            den_e_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q  <= mlc_pkg::PROD_W'(m_eff) * mlc_pkg::PROD_W'(num_c_q);
      den_d_q <= den_c_q;
      n2_q    <= mlc_pkg::N2_W'(prod_q) + mlc_pkg::N2_W'(den_d_q >> 1);
      den_e_q <= den_d_q;
    end
  end

  logic [QW-1:0] q;

  mlc_div #(
    .NW(mlc_pkg::N2_W),
    .DW(DENW),
    .QW(QW)
  ) u_div_out (
    .clk_i(clk_i),
    .en_i (en),
    .num_i(n2_q),
    .den_i(den_e_q),
    .quo_o(q)
  );

  // valid and side-band lines
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[TOT-2:0], in_valid_i};
      out_valid_q <= vld_q[TOT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fl_q[0] <= fl_a;
      for (int i = 1; i < TOT; i++) begin
        fl_q[i] <= fl_q[i-1];
      end
      ls_q[0].below_one <= ku_q < ONE_P;
      ls_q[0].ku_lo     <= ku_q[NUMW-1:0];
      for (int i = 1; i < LAT; i++) begin
        ls_q[i] <= ls_q[i-1];
      end
    end
  end

  // output stage: saturate and apply sign
  mlc_pkg::flag_t fl_o;
  logic [SB-2:0]  mag;
  logic [SB-1:0]  mag_ext;
  logic [SB-1:0]  out_d;

  assign fl_o = fl_q[TOT-1];

  always_comb begin
    if (fl_o.zero) begin
      mag = '0;
    end else if (fl_o.over) begin
      mag = FULL;
    end else if (CW2'(q) > CW2'(FULL)) begin
      mag = FULL;
    end else begin
      mag = (SB-1)'(q);
    end
    mag_ext = {1'b0, mag};
    out_d   = fl_o.neg ? (~mag_ext + SB'(1)) : mag_ext;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sample_out_q <= out_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = signed'(sample_out_q);

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld_q[0])
    else $error("transfer not entered into pipeline");

  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(vld_q))
    else $error("valid line moved during stall");

  a_norm_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[UW] && !fl_q[UW].over && !fl_q[UW].zero) |-> (u <= UW'(ONE_L)))
    else $error("normalised magnitude above one");

  a_no_min_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (sample_out_q != {1'b1, {(SB-1){1'b0}}}))
    else $error("result outside symmetric range");

endmodule

FILE: tb/sv/tb_mu_a_law_compressor_core.sv
// ----------------------------------------------------------------------------
// tb_mu_a_law_compressor_core
// Self-checking bench for the continuous mu-law / A-law compressor. It
// predicts each compressed sample in fixed point from the register settings,
// queues the prediction when the input transfer happens and compares it with
// the output transfer. Both channels idle at random after the first phase;
// the registers are rewritten between phases once the pipeline has drained.
// ----------------------------------------------------------------------------
module tb_mu_a_law_compressor_core;

  localparam int                            SW        = 16;
  localparam int                            LATENCY   = 66;
  localparam int                            LIMIT     = 400000;
  localparam logic [mlc_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [63:0]                   ONE_P     = 64'd1 << mlc_pkg::FRAC_P;
  localparam logic [63:0]                   ONE_L     = 64'd1 << mlc_pkg::FRAC_U;

  class compand_scoreboard;
    logic [SW-1:0] expected_q[$];
    int            errors;
    int            checked;

    function void note(logic [SW-1:0] value);
      expected_q.push_back(value);
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check(logic [SW-1:0] got);
      logic [SW-1:0] want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected sample_out %0d", $signed(got)));
      end else begin
        want = expected_q.pop_front();
        checked++;
        if (got !== want)
          report($sformatf("sample_out %0d, expected %0d", $signed(got), $signed(want)));
      end
    endtask
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic signed [SW-1:0]          sample_in_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic signed [SW-1:0]          sample_out_o;
  logic                          cfg_we_i = 1'b0;
  logic [mlc_pkg::CFG_IDX_W-1:0] cfg_idx_i = mlc_pkg::REG_LAW;
  logic [mlc_pkg::CFG_W-1:0]     cfg_data_i = '0;

  mlc_pkg::law_e             law_sel = mlc_pkg::LAW_MU;
  logic [mlc_pkg::K_W-1:0]   k_reg = mlc_pkg::K_ONE;
  logic [mlc_pkg::MAG_W-1:0] max_reg = 15'd32767;
  logic                      quiet = 1'b1;
  int                        cycles = 0;
  int                        sent = 0;
  compand_scoreboard         sb = new();

  mu_a_law_compressor_core #(.SAMPLE_BITS(SW)) dut (.*);

  always #10 clk_i = ~clk_i;

  function automatic logic [63:0] ln_fixed(logic [63:0] v);
    logic [63:0] t, m, frac, l2;
    int          p, e;
    if (v < ONE_P) return 64'd0;
    t = v;
    p = 0;
    frac = '0;
    while (t > 64'd1) begin
      t = t >> 1;
      p++;
    end
    e = p - mlc_pkg::FRAC_P;
    m = (p <= 30) ? (v << (30 - p)) : (v >> (p - 30));
    for (int i = 0; i < mlc_pkg::FRAC_U; i++) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac[mlc_pkg::FRAC_U-1-i] = 1'b1;
      end
    end
    l2 = (64'(e) << mlc_pkg::FRAC_U) | frac;
    return (l2 * 64'(mlc_pkg::LN2_Q32) + (64'd1 << 31)) >> 32;
  endfunction

  function automatic logic [63:0] div_near(logic [63:0] n, logic [63:0] d);
    if (d == 0) return 64'd0;
    return (n + d / 2) / d;
  endfunction

  function automatic logic [SW-1:0] compress_sample(logic [SW-1:0] x);
    logic        neg;
    logic [63:0] a, mval, k, u, ku, mag, den;
    neg  = x[SW-1];
    a    = neg ? ((64'd1 << SW) - 64'(x)) : 64'(x);
    mval = (max_reg == 0) ? 64'd1 : 64'(max_reg);
    k    = (k_reg < mlc_pkg::K_ONE) ? 64'(mlc_pkg::K_ONE) : 64'(k_reg);
    if (a == 0) begin
      mag = 0;
    end else if (a > mval) begin
      mag = (64'd1 << (SW - 1)) - 1;
    end else begin
      u  = div_near(a << mlc_pkg::FRAC_U, mval);
      ku = k * u;
      if (law_sel == mlc_pkg::LAW_MU) begin
        mag = div_near(mval * ln_fixed(ONE_P + ku),
                       ln_fixed(ONE_P + (k << mlc_pkg::FRAC_U)));
      end else begin
        den = ONE_L + ln_fixed(k << mlc_pkg::FRAC_U);
        if (ku < ONE_P)
          mag = div_near(mval * ku, den << (mlc_pkg::FRAC_P - mlc_pkg::FRAC_U));
        else mag = div_near(mval * (ONE_L + ln_fixed(ku)), den);
      end
      if (mag > (64'd1 << (SW - 1)) - 1) mag = (64'd1 << (SW - 1)) - 1;
    end
    return neg ? SW'(-mag) : SW'(mag);
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_mu_a_law_compressor_core: FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) sb.note(compress_sample(sample_in_i));
    if (rst_ni && out_valid_o && !out_stall_i) sb.check(sample_out_o);
  end

  always @(posedge clk_i)
    out_stall_i <= quiet ? 1'b0 : ($urandom_range(0, 99) < 9);

  task automatic send_sample(logic [SW-1:0] x);
    if (!quiet) begin
      while ($urandom_range(0, 99) < 9) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i  <= 1'b1;
    sample_in_i <= x;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [mlc_pkg::CFG_IDX_W-1:0] idx,
                           logic [mlc_pkg::CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      mlc_pkg::REG_LAW: law_sel = mlc_pkg::law_e'(data[0]);
      mlc_pkg::REG_K:   k_reg = data[mlc_pkg::K_W-1:0];
      mlc_pkg::REG_MAX: max_reg = data[mlc_pkg::MAG_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_law(logic law, logic [mlc_pkg::K_W-1:0] k,
                         logic [mlc_pkg::MAG_W-1:0] m);
    drain();
    write_reg(mlc_pkg::REG_LAW, {(mlc_pkg::CFG_W-1)'($urandom), law});
    write_reg(mlc_pkg::REG_K, k);
    write_reg(mlc_pkg::REG_MAX, {1'($urandom), m});
    write_reg(REG_SPARE, mlc_pkg::CFG_W'($urandom));
  endtask

  task automatic run_edges();
    logic [SW-1:0] m;
    m = SW'(max_reg == 0 ? 1 : max_reg);
    send_sample('0);
    send_sample(16'sd1);
    send_sample(-16'sd1);
    send_sample(16'sd32767);
    send_sample(-16'sd32768);
    send_sample(m);
    send_sample(-m);
    send_sample(m + SW'(1));
    send_sample(-(m + SW'(1)));
    send_sample(m - SW'(1));
    send_sample(m >> 1);
    send_sample(-(m >> 3));
  endtask

  task automatic run_random(int n);
    int            mm;
    logic [SW-1:0] x;
    mm = (max_reg == 0) ? 1 : max_reg;
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) begin
        x = SW'($urandom);
      end else begin
        x = SW'($urandom_range(0, mm));
        if ($urandom_range(0, 1)) x = -x;
      end
      send_sample(x);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_edges();
    run_random(150);
    quiet = 1'b0;
    set_law(mlc_pkg::LAW_A, 16'hFFFF, 15'd1);
    run_edges();
    run_random(100);
    set_law(mlc_pkg::LAW_MU, 16'hFFFF, 15'd32767);
    run_edges();
    run_random(150);
    set_law(mlc_pkg::LAW_A, mlc_pkg::K_ONE, 15'd32767);
    run_edges();
    run_random(150);
    set_law(mlc_pkg::LAW_A, 16'd22426, 15'd32767);
    run_edges();
    run_random(150);
    set_law(mlc_pkg::LAW_MU, 16'd65280, 15'd1000);
    run_edges();
    run_random(150);
    set_law(mlc_pkg::LAW_MU, 16'd100, 15'd0);
    run_edges();
    run_random(60);
    set_law(mlc_pkg::LAW_A, 16'd0, 15'd7);
    run_edges();
    run_random(80);
    repeat (3) begin
      set_law(1'($urandom), 16'($urandom_range(256, 65535)), 15'($urandom_range(1, 32767)));
      run_edges();
      run_random(130);
    end
    drain();
    $display("covered %0d samples over both laws, K and full-scale extremes, %0d results checked",
             sent, sb.checked);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb_mu_a_law_compressor_core: PASS");
    end else begin
      $display("tb_mu_a_law_compressor_core: FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/mlc_pkg.sv
hdl/mlc_div.sv
hdl/mlc_ln.sv
hdl/mu_a_law_compressor_core.sv
tb/sv/tb_mu_a_law_compressor_core.sv
